@@ design/srad_pkg.sv @@
// Shared types and constants for the sparse row accumulator with ReLU drain.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srad_pkg;

  // Table geometry
  localparam int ROWS   = 8192;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int VAL_W  = 32;
  localparam int ACT_W  = 31;
  localparam int BIAS_W = 22;
  localparam int CFG_W  = 31;

  // Front-to-back queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register reset values (bias unsigned Q6.16, ceiling unsigned Q15.16)
  localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(19661);
  localparam logic [ACT_W-1:0]  CEIL_RESET = ACT_W'(2097152);

  // Input commands
  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_BIAS = 1'b0,
    CFG_CEIL = 1'b1
  } cfg_index_t;

  // Work handed from the front to the back
  typedef enum logic {
    OP_ACC   = 1'b0,
    OP_DRAIN = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [ROW_W-1:0]  row;
    logic [VAL_W-1:0]  value;
    logic              last;
  } op_t;

  // Configuration seen by the back
  typedef struct packed {
    logic [BIAS_W-1:0] bias;
    logic [ACT_W-1:0]  ceiling;
  } cfg_t;

  // Back status toward the front
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Back sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } back_state_t;

endpackage

`default_nettype wire

@@ design/srad_front.sv @@
// Front end: accepts input transactions, tracks the drain position and
// turns each item into a table operation. Depends on srad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srad_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    cmd,
  input  wire logic [srad_pkg::ROW_W-1:0]    row_index,
  input  wire logic [srad_pkg::VAL_W-1:0]    value,
  input  wire logic [srad_pkg::ROW_W-1:0]    drain_limit,
  input  wire srad_pkg::back_status_t        back_status,
  input  wire logic                          queue_full,
  output logic                               enq,
  output srad_pkg::op_t                      enq_op
);

  logic                         draining;
  logic                         draining_next;
  logic [srad_pkg::ROW_W-1:0]   drain_end;
  logic [srad_pkg::ROW_W-1:0]   drain_end_next;
  logic [srad_pkg::ROW_W-1:0]   drain_pos;
  logic [srad_pkg::ROW_W-1:0]   drain_pos_next;
  logic                         accept;
  logic                         at_end;

  // Hold off input while the table is being cleared or the queue is full
  assign full   = queue_full | back_status.clearing;
  assign accept = push & ~full;
  assign at_end = (drain_pos >= drain_end);

  // Classify the item and advance the drain position
  always_comb begin
    draining_next  = draining;
    drain_end_next = drain_end;
    drain_pos_next = drain_pos;
    enq            = 1'b0;
    enq_op.kind    = srad_pkg::OP_ACC;
    enq_op.row     = row_index;
    enq_op.value   = value;
    enq_op.last    = 1'b0;
    if (accept) begin
      case (cmd)
        srad_pkg::CMD_ACC: begin
          // The row field spans the table, so every row is in range
          enq = 1'b1;
        end
        srad_pkg::CMD_START: begin
          // The limit field spans the table, so no clamp is needed
          draining_next  = 1'b1;
          drain_end_next = drain_limit;
          drain_pos_next = '0;
        end
        srad_pkg::CMD_TICK: begin
          if (draining) begin
            enq         = 1'b1;
            enq_op.kind = srad_pkg::OP_DRAIN;
            enq_op.row  = drain_pos;
            enq_op.last = at_end;
            if (at_end) begin
              draining_next  = 1'b0;
              drain_pos_next = '0;
            end else begin
              drain_pos_next = drain_pos + 1'b1;
            end
          end
        end
        default: begin
          // Unused command: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining  <= 1'b0;
      drain_end <= '0;
      drain_pos <= '0;
    end else begin
      draining  <= draining_next;
      drain_end <= drain_end_next;
      drain_pos <= drain_pos_next;
    end
  end

endmodule

`default_nettype wire

@@ design/srad_queue.sv @@
// Short operation queue between the front and the back of the block.
// Depends on srad_pkg for the operation type and depth.
`timescale 1ns / 1ps
`default_nettype none

module srad_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            enq,
  input  wire srad_pkg::op_t   enq_op,
  output logic                 queue_full,
  input  wire logic            deq,
  output logic                 queue_empty,
  output srad_pkg::op_t        head_op
);

  srad_pkg::op_t                slots [srad_pkg::QUEUE_DEPTH];
  logic [srad_pkg::QPTR_W-1:0]  wr_ptr;
  logic [srad_pkg::QPTR_W-1:0]  rd_ptr;
  logic [srad_pkg::QPTR_W:0]    count;

  assign queue_full  = (count == (srad_pkg::QPTR_W+1)'(srad_pkg::QUEUE_DEPTH));
  assign queue_empty = (count == '0);
  assign head_op     = slots[rd_ptr];

  // Store incoming operations
  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_op;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/srad_back.sv @@
// Back end: row-sum table, clearing pass, read-modify-write of the sums,
// biased clipped ReLU and the result register. Depends on srad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srad_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire srad_pkg::cfg_t                cfg,
  input  wire logic                          queue_empty,
  input  wire srad_pkg::op_t                 head_op,
  output logic                               deq,
  output srad_pkg::back_status_t             back_status,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [srad_pkg::ACT_W-1:0]         activation,
  output logic [srad_pkg::ROW_W-1:0]         out_row,
  output logic                               last
);

  localparam logic [srad_pkg::ROW_W-1:0] LAST_ROW = srad_pkg::ROW_W'(srad_pkg::ROWS - 1);

  // Row-sum table
  logic [srad_pkg::VAL_W-1:0]   mem [srad_pkg::ROWS];
  logic                         mem_we;
  logic [srad_pkg::ROW_W-1:0]   mem_waddr;
  logic [srad_pkg::VAL_W-1:0]   mem_wdata;
  logic                         mem_re;
  logic [srad_pkg::VAL_W-1:0]   rdata;

  srad_pkg::back_state_t        state;
  srad_pkg::back_state_t        state_next;
  logic [srad_pkg::ROW_W-1:0]   clr_addr;
  srad_pkg::op_t                cur_op;

  logic                         out_valid;
  logic                         slot_free;
  logic                         load_out;
  logic                         exec_go;

  logic signed [srad_pkg::VAL_W:0] sum_wide;
  logic [srad_pkg::VAL_W-1:0]      sum_sat;
  logic signed [srad_pkg::VAL_W:0] diff;
  logic signed [srad_pkg::VAL_W:0] ceil_wide;
  logic [srad_pkg::ACT_W-1:0]      act_val;

  assign slot_free = ~out_valid | pop;
  assign exec_go   = (state == srad_pkg::BK_EXEC) &&
                     ((cur_op.kind == srad_pkg::OP_ACC) || slot_free);

  // Saturating add of the stored sum and the operand
  always_comb begin
    sum_wide = $signed({rdata[srad_pkg::VAL_W-1], rdata}) +
               $signed({cur_op.value[srad_pkg::VAL_W-1], cur_op.value});
    if (sum_wide[srad_pkg::VAL_W] != sum_wide[srad_pkg::VAL_W-1]) begin
      sum_sat = sum_wide[srad_pkg::VAL_W] ? {1'b1, {(srad_pkg::VAL_W-1){1'b0}}}
                                          : {1'b0, {(srad_pkg::VAL_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[srad_pkg::VAL_W-1:0];
    end
  end

  // Subtract bias, then clamp between zero and the ceiling
  always_comb begin
    diff = $signed({rdata[srad_pkg::VAL_W-1], rdata}) -
           $signed({{(srad_pkg::VAL_W+1-srad_pkg::BIAS_W){1'b0}}, cfg.bias});
    ceil_wide = $signed({{(srad_pkg::VAL_W+1-srad_pkg::ACT_W){1'b0}}, cfg.ceiling});
    if (diff <= 0) begin
      act_val = '0;
    end else if (diff >= ceil_wide) begin
      act_val = cfg.ceiling;
    end else begin
      act_val = diff[srad_pkg::ACT_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      srad_pkg::BK_CLEAR: begin
        if (clr_addr == LAST_ROW) begin
          state_next = srad_pkg::BK_IDLE;
        end
      end
      srad_pkg::BK_IDLE: begin
        if (!queue_empty) begin
          state_next = srad_pkg::BK_EXEC;
        end
      end
      srad_pkg::BK_EXEC: begin
        if (exec_go) begin
          state_next = srad_pkg::BK_IDLE;
        end
      end
      default: state_next = srad_pkg::BK_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mem_we               = 1'b0;
    mem_waddr            = cur_op.row;
    mem_wdata            = '0;
    mem_re               = 1'b0;
    deq                  = 1'b0;
    load_out             = 1'b0;
    back_status.clearing = 1'b0;
    case (state)
      srad_pkg::BK_CLEAR: begin
        back_status.clearing = 1'b1;
        mem_we               = 1'b1;
        mem_waddr            = clr_addr;
      end
      srad_pkg::BK_IDLE: begin
        if (!queue_empty) begin
          deq    = 1'b1;
          mem_re = 1'b1;
        end
      end
      srad_pkg::BK_EXEC: begin
        if (exec_go) begin
          mem_we = 1'b1;
          if (cur_op.kind == srad_pkg::OP_ACC) begin
            mem_wdata = sum_sat;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      default: begin
        back_status.clearing = 1'b1;
      end
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[head_op.row];
    end
  end

  // Latch the operation being executed
  always_ff @(posedge clk) begin
    if (deq) begin
      cur_op <= head_op;
    end
  end

  // Sequencer and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= srad_pkg::BK_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == srad_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      activation <= act_val;
      out_row    <= cur_op.row;
      last       <= cur_op.last;
    end
  end

  assign empty = ~out_valid;

endmodule

`default_nettype wire

@@ design/sparse_row_accumulate_relu_drain.sv @@
// Sparse row accumulator with biased, clipped ReLU drain: top level.
// Holds the configuration registers and joins front, queue and back.
// Depends on srad_pkg, srad_front, srad_queue and srad_back.
//
// Usage:
//   Input is a queue write side: an item (cmd, row_index, value, drain_limit)
//   is taken on a clock edge with push high and full low. Results come out of
//   a queue read side: while empty is low the oldest result (activation,
//   out_row, last) is on the ports, and it is taken on an edge with pop high.
//   Registers bias and clip_ceiling are written through cfg_write / cfg_index /
//   cfg_data, by the user only while no transaction is in flight (unchecked).
// Flow:
//   Start-drain, ticks while idle and unused commands are resolved in the
//   front. Accumulates and drain ticks pass a 4-entry queue to the back,
//   which handles each with one table read, then one table write, and
//   takes no new one before it is done. A drain result is loaded into the
//   result register with the write, once the previous result is taken.
// Reset:
//   rst (synchronous) resets the registers and starts a clearing pass
//   over all 8192 rows of the table; full stays high during that pass.
// Stalls:
//   With a result waiting and pop low, the back holds the next drain row
//   and the queue fills; full then rises until results are taken.
`timescale 1ns / 1ps
`default_nettype none

module sparse_row_accumulate_relu_drain (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    cmd,
  input  wire logic [srad_pkg::ROW_W-1:0]    row_index,
  input  wire logic [srad_pkg::VAL_W-1:0]    value,
  input  wire logic [srad_pkg::ROW_W-1:0]    drain_limit,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [srad_pkg::ACT_W-1:0]         activation,
  output logic [srad_pkg::ROW_W-1:0]         out_row,
  output logic                               last,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [srad_pkg::CFG_W-1:0]    cfg_data
);

  srad_pkg::cfg_t          cfg;
  srad_pkg::back_status_t  back_status;
  srad_pkg::op_t           enq_op;
  srad_pkg::op_t           head_op;
  logic                    enq;
  logic                    deq;
  logic                    queue_full;
  logic                    queue_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bias    <= srad_pkg::BIAS_RESET;
      cfg.ceiling <= srad_pkg::CEIL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        srad_pkg::CFG_BIAS: cfg.bias    <= cfg_data[srad_pkg::BIAS_W-1:0];
        srad_pkg::CFG_CEIL: cfg.ceiling <= cfg_data[srad_pkg::ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srad_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .row_index   (row_index),
    .value       (value),
    .drain_limit (drain_limit),
    .back_status (back_status),
    .queue_full  (queue_full),
    .enq         (enq),
    .enq_op      (enq_op)
  );

  srad_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .enq         (enq),
    .enq_op      (enq_op),
    .queue_full  (queue_full),
    .deq         (deq),
    .queue_empty (queue_empty),
    .head_op     (head_op)
  );

  srad_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .head_op     (head_op),
    .deq         (deq),
    .back_status (back_status),
    .empty       (empty),
    .pop         (pop),
    .activation  (activation),
    .out_row     (out_row),
    .last        (last)
  );

endmodule

`default_nettype wire
